// ----- rtl/bart_pkg.sv -----
// Package with constants, types and helpers shared by the block average ring dump design.
package bart_pkg;

  localparam int SampleWidth = 12;
  localparam int SumWidth = 18;
  localparam int CountWidth = 6;
  localparam int SumShift = 4;
  localparam int SamplesPerAverage = 1 << SumShift;
  localparam int RingDepth = 20;
  localparam int PosWidth = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam logic [SampleWidth-1:0] ThresholdReset = 12'd2000;

  typedef logic [PosWidth-1:0] pos_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StShow
  } state_e;

  typedef struct packed {
    logic accept;
    logic start_dump;
    logic read;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic trigger;
    logic last;
  } status_t;

  function automatic pos_t next_pos(input pos_t pos);
    pos_t nxt;
    if (pos == PosWidth'(RingDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/bart_if.sv -----
// Valid/ready channel interfaces for sample items and reading items.
interface bart_in_if;
  logic                                valid;
  logic                                ready;
  logic [bart_pkg::SampleWidth-1:0]    adc_sample;
  modport source(output valid, output adc_sample, input ready);
  modport sink(input valid, input adc_sample, output ready);
endinterface

interface bart_out_if;
  logic                                valid;
  logic                                ready;
  logic [bart_pkg::SampleWidth-1:0]    reading;
  logic                                last_of_dump;
  modport source(output valid, output reading, output last_of_dump, input ready);
  modport sink(input valid, input reading, input last_of_dump, output ready);
endinterface

// ----- rtl/bart_ctrl.sv -----
// Controller state machine that sequences sample intake and ring dumps.
module bart_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bart_pkg::status_t status_i,
  output bart_pkg::cmd_t    cmd_o
);

  bart_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bart_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bart_pkg::StIdle: begin
        if (in_valid_i && status_i.block_end && status_i.trigger) begin
          state_d = bart_pkg::StRead;
        end
      end
      bart_pkg::StRead: begin
        state_d = bart_pkg::StShow;
      end
      bart_pkg::StShow: begin
        if (out_ready_i) begin
          state_d = status_i.last ? bart_pkg::StIdle : bart_pkg::StRead;
        end
      end
      default: begin
        state_d = bart_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      bart_pkg::StIdle: begin
        in_ready_o       = 1'b1;
        cmd_o.accept     = in_valid_i;
        cmd_o.start_dump = in_valid_i && status_i.block_end && status_i.trigger;
        cmd_o.finish     = in_valid_i && status_i.block_end && !status_i.trigger;
      end
      bart_pkg::StRead: begin
        cmd_o.read = 1'b1;
      end
      bart_pkg::StShow: begin
        out_valid_o  = 1'b1;
        cmd_o.step   = out_ready_i && !status_i.last;
        cmd_o.finish = out_ready_i && status_i.last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/bart_dp.sv -----
// Datapath with the block sum, the averaging ring memory and the dump read pointer.
module bart_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bart_pkg::SampleWidth-1:0] cfg_wdata_i,
  input  logic [bart_pkg::SampleWidth-1:0] adc_sample_i,
  input  bart_pkg::cmd_t                   cmd_i,
  output bart_pkg::status_t                status_o,
  output logic [bart_pkg::SampleWidth-1:0] reading_o,
  output logic                             last_of_dump_o
);

  logic [bart_pkg::SampleWidth-1:0] thr_q;
  logic [bart_pkg::SumWidth-1:0]    sum_q, sum_d;
  logic [bart_pkg::CountWidth-1:0]  count_q;
  bart_pkg::pos_t                   wp_q;
  bart_pkg::pos_t                   rd_pos_q;
  logic [bart_pkg::RingDepth-1:0]   ring_vld_q;
  logic [bart_pkg::SampleWidth-1:0] ring_mem [bart_pkg::RingDepth];
  logic [bart_pkg::SampleWidth-1:0] rd_mem_q;
  logic                             rd_vld_q;
  logic [bart_pkg::SampleWidth-1:0] mean;
  logic                             block_end;

  assign sum_d     = sum_q + bart_pkg::SumWidth'(adc_sample_i);
  assign block_end = count_q == bart_pkg::CountWidth'(bart_pkg::SamplesPerAverage - 1);
  assign mean      = sum_d[bart_pkg::SumShift +: bart_pkg::SampleWidth];

  assign status_o.block_end = block_end;
  assign status_o.trigger   = mean > thr_q;
  assign status_o.last      = rd_pos_q == wp_q;

  assign reading_o      = rd_vld_q ? rd_mem_q : '0;
  assign last_of_dump_o = rd_pos_q == wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= bart_pkg::ThresholdReset;
      sum_q      <= '0;
      count_q    <= '0;
      wp_q       <= '0;
      rd_pos_q   <= '0;
      ring_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (block_end) begin
          sum_q            <= '0;
          count_q          <= '0;
          ring_vld_q[wp_q] <= 1'b1;
        end else begin
          sum_q   <= sum_d;
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.start_dump) begin
        rd_pos_q <= bart_pkg::next_pos(wp_q);
      end else if (cmd_i.step) begin
        rd_pos_q <= bart_pkg::next_pos(rd_pos_q);
      end
      if (cmd_i.finish) begin
        wp_q <= bart_pkg::next_pos(wp_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && block_end) begin
      ring_mem[wp_q] <= mean;
    end
    if (cmd_i.read) begin
      rd_mem_q <= ring_mem[rd_pos_q];
      rd_vld_q <= ring_vld_q[rd_pos_q];
    end
  end

endmodule

// ----- rtl/block_average_ring_threshold_dump.sv -----
// Top level of the block average decimator with threshold-triggered ring dump.
// A sample item is taken while the controller is idle; the block-ending sample writes its mean to the ring.
// A dump that follows gives each reading item by a memory read state, then an output state,
// and all 20 readings of a full dump, with any output stalls, pass before the next sample is taken.
// Reset clears the sum, count, write position and ring valid bits, so unwritten slots read
// zero, and sets the threshold to 2000.
module block_average_ring_threshold_dump (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bart_pkg::SampleWidth-1:0] cfg_wdata_i,
  bart_in_if.sink                          smp_i,
  bart_out_if.source                       res_o
);

  bart_pkg::cmd_t    cmd;
  bart_pkg::status_t status;

  bart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bart_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .adc_sample_i   (smp_i.adc_sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .reading_o      (res_o.reading),
    .last_of_dump_o (res_o.last_of_dump)
  );

endmodule

// ----- sim/tb_block_average_ring_threshold_dump.sv -----
// Testbench for the block average ring dump: directed blocks, then random samples checked by a predictor.
module tb_block_average_ring_threshold_dump;

  localparam int SamplesPerAverage = bart_pkg::SamplesPerAverage;
  localparam int RingDepth = bart_pkg::RingDepth;
  localparam int IdlePercent = 17;
  localparam int RandomItems = 134;
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 60;
  localparam int WatchdogLimit = 4000;
  localparam int MaxPrinted = 40;

  typedef logic [bart_pkg::SampleWidth-1:0] sample_t;
  typedef bart_pkg::pos_t pos_t;

  typedef struct packed {
    sample_t reading;
    logic    last;
  } reading_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_QUIET,
    CHECK_FRESH_RING
  } check_e;

  typedef struct packed {
    logic    wr;
    sample_t thr;
    sample_t level;
    logic [3:0] tail;
    logic    alt;
    check_e  kind;
    sample_t newest;
  } block_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  sample_t cfg_wdata_i;
  logic calm;
  int errors;
  int quiet_cycles;

  bart_in_if smp_if ();
  bart_out_if res_if ();

  block_average_ring_threshold_dump u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp_i      (smp_if),
    .res_o      (res_if)
  );

  logic [bart_pkg::SumWidth-1:0]   acc_sum;
  logic [bart_pkg::CountWidth-1:0] acc_count;
  sample_t                         ring[RingDepth];
  pos_t                            wr_pos;
  sample_t                         threshold_q;
  reading_t                        dump_readings[$];
  reading_t                        expected_readings[$];

  block_row_t block_rows[6] = '{
    '{1'b0, 12'd2000, 12'd4095, 4'd0,  1'b0, CHECK_FRESH_RING, 12'd4095},
    '{1'b1, 12'd4095, 12'd4095, 4'd0,  1'b0, CHECK_QUIET,      12'd0},
    '{1'b1, 12'd0,    12'd0,    4'd0,  1'b0, CHECK_QUIET,      12'd0},
    '{1'b1, 12'd1000, 12'd1000, 4'd15, 1'b0, CHECK_QUIET,      12'd0},
    '{1'b1, 12'd999,  12'd1000, 4'd15, 1'b0, CHECK_MODEL,      12'd0},
    '{1'b1, 12'd2046, 12'h555,  4'd0,  1'b1, CHECK_MODEL,      12'd0}
  };

  function automatic pos_t step_pos(input pos_t p);
    return (p == pos_t'(RingDepth - 1)) ? pos_t'(0) : pos_t'(p + 1'b1);
  endfunction

  function automatic void average_sample(input sample_t s);
    sample_t mean;
    pos_t rd;
    dump_readings.delete();
    acc_sum = acc_sum + s;
    acc_count = acc_count + 1'b1;
    if (acc_count < SamplesPerAverage) return;
    mean = sample_t'(acc_sum / SamplesPerAverage);
    ring[wr_pos] = mean;
    if (mean > threshold_q) begin
      rd = step_pos(wr_pos);
      for (int k = 0; k < RingDepth; k++) begin
        dump_readings.push_back('{reading: ring[rd], last: (k == RingDepth - 1)});
        rd = step_pos(rd);
      end
    end
    wr_pos = step_pos(wr_pos);
    acc_sum = '0;
    acc_count = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic send_sample(input sample_t s, input check_e kind, input sample_t newest,
                             input logic is_last);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.adc_sample <= s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    average_sample(s);
    case (kind)
      CHECK_MODEL: begin
        foreach (dump_readings[i]) expected_readings.push_back(dump_readings[i]);
      end
      CHECK_FRESH_RING: begin
        if (is_last) begin
          for (int k = 0; k < RingDepth - 1; k++) expected_readings.push_back('{12'd0, 1'b0});
          expected_readings.push_back('{newest, 1'b1});
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_threshold(input sample_t v);
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_q = v;
  endtask

  function automatic sample_t pick_threshold();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd4095;
    return sample_t'($urandom_range(0, 4095));
  endfunction

  function automatic sample_t pick_sample(input int center);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd4095;
    if (r < 5) return sample_t'($urandom_range(0, 4095));
    v = center + $urandom_range(0, 510) - 255;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected reading %0d last %0b", res_if.reading,
                                  res_if.last_of_dump));
      end else begin
        want = expected_readings.pop_front();
        if (res_if.reading !== want.reading) begin
          report_mismatch($sformatf("reading %0d, expected %0d", res_if.reading, want.reading));
        end
        if (res_if.last_of_dump !== want.last) begin
          report_mismatch($sformatf("last_of_dump %0b, expected %0b", res_if.last_of_dump,
                                    want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int left;
    int n;
    int done;
    int center;
    sample_t s;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    calm = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    smp_if.valid = 1'b0;
    smp_if.adc_sample = '0;
    res_if.ready = 1'b0;
    acc_sum = '0;
    acc_count = '0;
    wr_pos = '0;
    threshold_q = bart_pkg::ThresholdReset;
    foreach (ring[i]) ring[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (block_rows[r]) begin
      if (block_rows[r].wr) write_threshold(block_rows[r].thr);
      for (int k = 0; k < SamplesPerAverage; k++) begin
        s = (block_rows[r].alt && k[0]) ? ~block_rows[r].level : block_rows[r].level;
        if (k == SamplesPerAverage - 1) s = s + block_rows[r].tail;
        send_sample(s, block_rows[r].kind, block_rows[r].newest, k == SamplesPerAverage - 1);
      end
    end

    left = RandomItems;
    done = 0;
    center = 2048;
    while (left > 0) begin
      n = $urandom_range(8, 48);
      if (n > left) n = left;
      write_threshold(pick_threshold());
      for (int k = 0; k < n; k++) begin
        calm <= (done >= 40 && done < 100);
        if (acc_count == 0) center = $urandom_range(0, 4095);
        send_sample(pick_sample(center), CHECK_MODEL, 12'd0, 1'b0);
        done++;
      end
      left -= n;
    end

    smp_if.valid <= 1'b0;
    calm <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
